/* hw/rtl/qcr_pkg.sv */
`timescale 1ns / 1ps

package qcr_pkg;

    // Fixed field widths of the ports
    localparam int CMD_WIDTH     = 2;
    localparam int PORT_TIME_W   = 32;
    localparam int PORT_COUNT_W  = 32;
    localparam int TIMEOUT_WIDTH = 32;

    // Default internal widths
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 32;

    // Stall timeout after reset, in microseconds
    localparam logic [TIMEOUT_WIDTH-1:0] STALL_TIMEOUT_RESET = 32'd100000;

    // Event codes
    localparam logic [CMD_WIDTH-1:0] CMD_EDGE_A = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_EDGE_B = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_TICK   = 2'd2;

    // Event held in the input register
    typedef struct packed {
        logic [CMD_WIDTH-1:0]   command;
        logic                   pin_level;
        logic [PORT_TIME_W-1:0] time_us;
    } qcr_event_t;

    // Pipeline control between the input register and the result register
    typedef struct packed {
        logic s1_valid;
        logic s2_ready;
    } qcr_ctl_t;

endpackage

/* hw/rtl/qcr_in_stage.sv */
`timescale 1ns / 1ps

module qcr_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  qcr_pkg::qcr_event_t in_event,
    input  logic                s2_ready,
    output qcr_pkg::qcr_ctl_t   ctl,
    output qcr_pkg::qcr_event_t s1_event
);
    import qcr_pkg::*;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    qcr_event_t s1_event_reg;
    logic       accept;
    logic       advance;

    // Hold the request while the result register cannot take it
    assign in_stall = s1_valid_reg && !s2_ready;
    assign accept   = in_valid && !in_stall;
    assign advance  = s1_valid_reg && s2_ready;

    // Track occupancy of the input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the payload on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_event_reg <= in_event;
        end
    end

    assign ctl.s1_valid = s1_valid_reg;
    assign ctl.s2_ready = s2_ready;
    assign s1_event     = s1_event_reg;

endmodule

/* hw/rtl/qcr_core.sv */
`timescale 1ns / 1ps

module qcr_core
#(
    parameter int COUNT_WIDTH = qcr_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = qcr_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  qcr_pkg::qcr_ctl_t                   ctl,
    input  qcr_pkg::qcr_event_t                 s1_event,
    input  logic [qcr_pkg::TIMEOUT_WIDTH-1:0]   stall_timeout_us,
    output logic [qcr_pkg::PORT_COUNT_W-1:0]    position_out,
    output logic [qcr_pkg::PORT_COUNT_W-1:0]    rate_out
);
    import qcr_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > TIMEOUT_WIDTH) ? TIME_WIDTH : TIMEOUT_WIDTH;

    logic                   level_a_reg;
    logic                   level_a_next;
    logic                   level_b_reg;
    logic                   level_b_next;
    logic [COUNT_WIDTH-1:0] position_reg;
    logic [COUNT_WIDTH-1:0] position_next;
    logic [COUNT_WIDTH-1:0] prev_sample_reg;
    logic [COUNT_WIDTH-1:0] prev_sample_next;
    logic [COUNT_WIDTH-1:0] rate_reg;
    logic [COUNT_WIDTH-1:0] rate_next;
    logic [TIME_WIDTH-1:0]  last_a_time_reg;
    logic [TIME_WIDTH-1:0]  last_a_time_next;
    logic [TIME_WIDTH-1:0]  now;
    logic [TIME_WIDTH-1:0]  elapsed;
    logic                   timed_out;
    logic                   advance;

    assign advance   = ctl.s1_valid && ctl.s2_ready;
    assign now       = TIME_WIDTH'(s1_event.time_us);
    assign elapsed   = now - last_a_time_reg;
    assign timed_out = CMP_W'(elapsed) > CMP_W'(stall_timeout_us);

    // Decode the event and step the counters
    always_comb
    begin
        level_a_next     = level_a_reg;
        level_b_next     = level_b_reg;
        position_next    = position_reg;
        prev_sample_next = prev_sample_reg;
        rate_next        = rate_reg;
        last_a_time_next = last_a_time_reg;
        if (advance)
        begin
            case (s1_event.command)
                CMD_EDGE_A:
                begin
                    last_a_time_next = now;
                    level_a_next     = s1_event.pin_level;
                    if (s1_event.pin_level == level_b_reg)
                    begin
                        position_next = position_reg - COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        position_next = position_reg + COUNT_WIDTH'(1);
                    end
                end
                CMD_EDGE_B:
                begin
                    level_b_next = s1_event.pin_level;
                    if (level_a_reg == s1_event.pin_level)
                    begin
                        position_next = position_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        position_next = position_reg - COUNT_WIDTH'(1);
                    end
                end
                CMD_TICK:
                begin
                    prev_sample_next = position_reg;
                    if (timed_out)
                    begin
                        rate_next = '0;
                    end
                    else
                    begin
                        rate_next = position_reg - prev_sample_reg;
                    end
                end
                default:
                begin
                    // Unused code: leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_a_reg     <= 1'b0;
            level_b_reg     <= 1'b0;
            position_reg    <= '0;
            prev_sample_reg <= '0;
            rate_reg        <= '0;
            last_a_time_reg <= '0;
        end
        else
        begin
            level_a_reg     <= level_a_next;
            level_b_reg     <= level_b_next;
            position_reg    <= position_next;
            prev_sample_reg <= prev_sample_next;
            rate_reg        <= rate_next;
            last_a_time_reg <= last_a_time_next;
        end
    end

    // Sign-extend or cut the counts to the port width
    assign position_out = PORT_COUNT_W'($signed(position_next));
    assign rate_out     = PORT_COUNT_W'($signed(rate_next));

endmodule

/* hw/rtl/qcr_out_stage.sv */
`timescale 1ns / 1ps

module qcr_out_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  qcr_pkg::qcr_ctl_t                   ctl,
    input  logic [qcr_pkg::PORT_COUNT_W-1:0]    position_in,
    input  logic [qcr_pkg::PORT_COUNT_W-1:0]    rate_in,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic                                s2_ready,
    output logic signed [qcr_pkg::PORT_COUNT_W-1:0] position,
    output logic signed [qcr_pkg::PORT_COUNT_W-1:0] rate
);
    import qcr_pkg::*;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [PORT_COUNT_W-1:0] position_reg;
    logic [PORT_COUNT_W-1:0] rate_reg;
    logic                    load;

    // Take a new result when empty or when the current one leaves
    assign s2_ready = !out_valid_reg || !out_stall;
    assign load     = ctl.s1_valid && ctl.s2_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until replaced
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            position_reg <= position_in;
            rate_reg     <= rate_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = $signed(position_reg);
    assign rate      = $signed(rate_reg);

endmodule

/* hw/rtl/quadrature_counter_with_rate.sv */
`timescale 1ns / 1ps

// Quadrature encoder counter (x4 decoding) with a per-tick rate. Each request
// is a phase A edge, a phase B edge or a sample tick, and each returns one
// result with the position after the event and the current rate. A request
// passes through an input register and then the result register; one request
// is taken every cycle when the output side does not stall.
// The stall timeout register is written through the cfg_valid/cfg_ready port,
// which is always ready, and resets to 100000 us. Write it only while idle.
module quadrature_counter_with_rate
#(
    parameter int COUNT_WIDTH = qcr_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = qcr_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qcr_pkg::TIMEOUT_WIDTH-1:0]       cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [qcr_pkg::CMD_WIDTH-1:0]           command,
    input  logic                                    pin_level,
    input  logic [qcr_pkg::PORT_TIME_W-1:0]         time_us,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [qcr_pkg::PORT_COUNT_W-1:0] position,
    output logic signed [qcr_pkg::PORT_COUNT_W-1:0] rate
);
    import qcr_pkg::*;

    logic [TIMEOUT_WIDTH-1:0] timeout_reg;
    qcr_event_t               in_event;
    qcr_event_t               s1_event;
    qcr_ctl_t                 ctl;
    logic                     s2_ready;
    logic [PORT_COUNT_W-1:0]  position_calc;
    logic [PORT_COUNT_W-1:0]  rate_calc;

    // Configuration write: always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= STALL_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    assign in_event.command   = command;
    assign in_event.pin_level = pin_level;
    assign in_event.time_us   = time_us;

    qcr_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_event (in_event),
        .s2_ready (s2_ready),
        .ctl      (ctl),
        .s1_event (s1_event)
    );

    qcr_core
    #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    )
    u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .s1_event         (s1_event),
        .stall_timeout_us (timeout_reg),
        .position_out     (position_calc),
        .rate_out         (rate_calc)
    );

    qcr_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .position_in (position_calc),
        .rate_in     (rate_calc),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .s2_ready    (s2_ready),
        .position    (position),
        .rate        (rate)
    );

endmodule

/* tb/sv/quadrature_counter_with_rate_chk.sv */
`timescale 1ns / 1ps

// Watch the request, result and register channels, predict each result and compare
module quadrature_counter_with_rate_chk
    import qcr_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [TIMEOUT_WIDTH-1:0]       cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [CMD_WIDTH-1:0]           command,
    input  logic                           pin_level,
    input  logic [PORT_TIME_W-1:0]         time_us,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [PORT_COUNT_W-1:0] position,
    input  logic signed [PORT_COUNT_W-1:0] rate,
    output int                             mismatches,
    output int                             outstanding
);

    typedef struct packed {
        logic [PORT_COUNT_W-1:0] position;
        logic [PORT_COUNT_W-1:0] rate;
    } reading_t;

    // Predicted encoder state
    logic                     lvl_a;
    logic                     lvl_b;
    logic [PORT_COUNT_W-1:0]  count_q;
    logic [PORT_COUNT_W-1:0]  last_tick_count;
    logic [PORT_COUNT_W-1:0]  rate_q;
    logic [PORT_TIME_W-1:0]   last_a_time;
    logic [TIMEOUT_WIDTH-1:0] timeout_us;

    reading_t readings_q[$];
    int       fail_count = 0;
    int       pending_n  = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending_n;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        fail_count++;
    endtask

    // Advance the encoder state by one request and queue the reading it yields
    task automatic predict_event(input logic [CMD_WIDTH-1:0] cmd, input logic lvl,
                                 input logic [PORT_TIME_W-1:0] t);
        logic [PORT_COUNT_W-1:0] delta;
        logic [PORT_TIME_W-1:0]  elapsed;
        case (cmd)
            CMD_EDGE_A:
            begin
                last_a_time = t;
                lvl_a       = lvl;
                if (lvl_a == lvl_b)
                    count_q = count_q - PORT_COUNT_W'(1);
                else
                    count_q = count_q + PORT_COUNT_W'(1);
            end
            CMD_EDGE_B:
            begin
                lvl_b = lvl;
                if (lvl_a == lvl_b)
                    count_q = count_q + PORT_COUNT_W'(1);
                else
                    count_q = count_q - PORT_COUNT_W'(1);
            end
            CMD_TICK:
            begin
                delta           = count_q - last_tick_count;
                elapsed         = t - last_a_time;
                last_tick_count = count_q;
                // drop the rate once the A phase has been quiet too long
                rate_q = (elapsed > timeout_us) ? '0 : delta;
            end
            default:
            begin
            end
        endcase
        readings_q.push_back('{position: count_q, rate: rate_q});
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_reading();
        reading_t want;
        if (readings_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: position %0d rate %0d",
                                      position, rate));
        end else begin
            want = readings_q.pop_front();
            if (position !== want.position)
                report_mismatch($sformatf("position: got %0d expected %0d",
                                          position, $signed(want.position)));
            if (rate !== want.rate)
                report_mismatch($sformatf("rate: got %0d expected %0d",
                                          rate, $signed(want.rate)));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lvl_a           = 1'b0;
            lvl_b           = 1'b0;
            count_q         = '0;
            last_tick_count = '0;
            rate_q          = '0;
            last_a_time     = '0;
            timeout_us      = STALL_TIMEOUT_RESET;
            readings_q.delete();
            pending_n       = 0;
        end else begin
            // register write takes effect for the requests after it
            if (cfg_valid && cfg_ready)
                timeout_us = cfg_data;
            if (in_valid && !in_stall)
                predict_event(command, pin_level, time_us);
            if (out_valid && !out_stall)
                check_reading();
            pending_n = readings_q.size();
        end
    end

endmodule

/* tb/sv/quadrature_counter_with_rate_tb.sv */
`timescale 1ns / 1ps

module quadrature_counter_with_rate_tb;

    import qcr_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 110;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [TIMEOUT_WIDTH-1:0]       cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [CMD_WIDTH-1:0]           command   = CMD_EDGE_A;
    logic                           pin_level = 1'b0;
    logic [PORT_TIME_W-1:0]         time_us   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [PORT_COUNT_W-1:0] position;
    logic signed [PORT_COUNT_W-1:0] rate;

    int mismatches;
    int outstanding;

    // Stimulus state: pin levels as last sent, time base, direction, idling window
    logic                   enc_a       = 1'b0;
    logic                   enc_b       = 1'b0;
    logic                   forward     = 1'b1;
    logic                   no_idle     = 1'b0;
    logic [PORT_TIME_W-1:0] now_us      = '0;
    int                     rand_sent   = 0;
    int                     stuck_count = 0;

    quadrature_counter_with_rate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .pin_level (pin_level),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position),
        .rate      (rate)
    );

    quadrature_counter_with_rate_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .pin_level   (pin_level),
        .time_us     (time_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .rate        (rate),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stall the result side at random, except inside the no-idle window
    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 11);
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                stuck_count <= 0;
            end else if (stuck_count >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stuck_count <= stuck_count + 1;
            end
        end
    end

    // Offer one request, idling first at random, and hold it until accepted
    task automatic send_event(input logic [CMD_WIDTH-1:0] cmd, input logic lvl,
                              input logic [PORT_TIME_W-1:0] t);
        if (!no_idle && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        pin_level <= lvl;
        time_us   <= t;
        if (cmd == CMD_EDGE_A)
            enc_a = lvl;
        else if (cmd == CMD_EDGE_B)
            enc_b = lvl;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    // Toggle whichever phase moves the count one step in the current direction
    task automatic send_quadrature_edge(input logic [PORT_TIME_W-1:0] t);
        if (forward == (enc_a == enc_b))
            send_event(CMD_EDGE_A, !enc_a, t);
        else
            send_event(CMD_EDGE_B, !enc_b, t);
    endtask

    // Hold the sender until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_WIDTH-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly clean quadrature motion with ticks, the rest noise
    task automatic send_random_items(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            no_idle <= (rand_sent >= 120 && rand_sent < 220);
            r = $urandom_range(0, 99);
            if (r < 80)
                now_us = now_us + $urandom_range(0, 200);
            else if (r < 92)
                now_us = now_us + $urandom_range(0, 5000);
            else if (r < 98)
                now_us = now_us + $urandom_range(0, 200000);
            else
                now_us = now_us + $urandom;
            if ($urandom_range(0, 99) < 5)
                forward = !forward;
            r = $urandom_range(0, 99);
            if (r < 60)
                send_quadrature_edge(now_us);
            else if (r < 85)
                send_event(CMD_TICK, 1'($urandom_range(0, 1)), now_us);
            else if (r < 95)
                send_event(CMD_WIDTH'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           now_us);
            else
                send_event(CMD_WIDTH'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           $urandom);
            rand_sent++;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick from reset, down count through zero, both directions
        send_event(CMD_TICK, 1'b1, 32'd0);
        send_event(CMD_EDGE_A, 1'b0, 32'd5);
        send_event(CMD_EDGE_B, 1'b1, 32'd10);
        send_event(CMD_EDGE_A, 1'b1, 32'd15);
        send_event(CMD_EDGE_B, 1'b0, 32'd20);
        forward = 1'b1;
        repeat (4) send_quadrature_edge(32'd30);
        send_event(CMD_TICK, 1'b0, 32'd40);
        // repeated level on the same phase, and the unused code
        send_event(CMD_EDGE_A, enc_a, 32'd50);
        send_event(CMD_EDGE_B, enc_b, 32'd55);
        send_event(CMD_TICK + 2'd1, 1'b1, 32'hFFFF_FFFF);
        send_event(CMD_TICK + 2'd1, 1'b0, 32'd0);
        // timeout boundary with the reset value: equal keeps, one more drops
        send_event(CMD_EDGE_A, !enc_a, 32'd1000);
        send_event(CMD_TICK, 1'b0, 32'd101000);
        send_event(CMD_EDGE_B, !enc_b, 32'd101000);
        send_event(CMD_TICK, 1'b1, 32'd101001);
        // elapsed time across the timestamp wrap
        send_event(CMD_EDGE_A, !enc_a, 32'hFFFF_FFF0);
        send_event(CMD_TICK, 1'b0, 32'h0000_0010);
        // edge and tick at the same timestamp
        send_event(CMD_EDGE_A, !enc_a, 32'd5000);
        send_event(CMD_TICK, 1'b0, 32'd5000);
        send_event(CMD_TICK, 1'b0, 32'hFFFF_FFFF);

        now_us = $urandom;
        send_random_items(PHASE_ITEMS);
        write_timeout('0);
        send_random_items(PHASE_ITEMS);
        write_timeout('1);
        send_random_items(PHASE_ITEMS);
        write_timeout($urandom_range(1, 3000));
        send_random_items(PHASE_ITEMS);
        write_timeout($urandom);
        send_random_items(PHASE_ITEMS);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qcr_pkg.sv
hw/rtl/qcr_in_stage.sv
hw/rtl/qcr_core.sv
hw/rtl/qcr_out_stage.sv
hw/rtl/quadrature_counter_with_rate.sv
tb/sv/quadrature_counter_with_rate_chk.sv
tb/sv/quadrature_counter_with_rate_tb.sv
